>>> design/ust_pkg.sv
package ust_pkg;

    localparam logic [10:0] MIN_PKT_LEN   = 11'd5;
    localparam logic [15:0] TIMEOUT_RESET = 16'd200;

    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_STALE    = 2'd3;

    localparam logic RK_STATUS = 1'b0;
    localparam logic RK_UPDATE = 1'b1;

    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
        logic [31:0] last_seen;
        logic [31:0] recv_seq;
        logic [31:0] send_seq;
        logic [7:0]  down;
        logic [7:0]  pressed;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [5:0]  slot;
        logic [31:0] addr;
        logic [15:0] port;
        logic [31:0] send_seq;
        logic [7:0]  down;
        logic [7:0]  pressed;
    } res_t;

    typedef struct packed {
        logic accept;
        logic start;
        logic idx_inc;
        logic scan_eval;
        logic commit;
        logic hold_short;
        logic evict;
        logic tick_upd;
        logic push;
        logic push_last;
    } cmd_t;

    typedef struct packed {
        logic kind_tick;
        logic short_pkt;
        logic live;
        logic match;
        logic evict;
        logic last_idx;
        logic hold_valid;
        logic out_free;
    } sts_t;

endpackage

>>> design/udp_session_table_unit.sv
// Channel   Handshake            Contents
// s_*       s_valid / s_ready    one request: a received packet or a server tick
// m_*       m_valid / m_ready    status or client update results, m_last on the final one
// cfg_*     cfg_wr_en            timeout_ticks, written at once
//
// A packet request searches the table slot by slot, reading each slot through the
// registered read port of the slot memory; a packet shorter than MIN_PKT_LEN skips it.
// A tick request walks every slot the same way, updating or evicting each live one.
// Either request also waits while m_ready holds back one of its results.
// Reset clears the tick counter and the live bits and sets the timeout register to 200.
// A new request is taken only after the previous one has placed its last result, if it had one.
module udp_session_table_unit
    import ust_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [31:0] s_src_addr,
    input  logic [15:0] s_src_port,
    input  logic [10:0] s_pkt_length,
    input  logic [31:0] s_seq_number,
    input  logic [7:0]  s_buttons,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [1:0]  m_status,
    output logic [5:0]  m_slot,
    output logic [31:0] m_peer_addr,
    output logic [15:0] m_peer_port,
    output logic [31:0] m_send_seq,
    output logic [7:0]  m_buttons_down,
    output logic [7:0]  m_buttons_pressed,
    output logic        m_last
);

    cmd_t cmd;
    sts_t sts;

    ust_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ust_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .s_kind            (s_kind),
        .s_src_addr        (s_src_addr),
        .s_src_port        (s_src_port),
        .s_pkt_length      (s_pkt_length),
        .s_seq_number      (s_seq_number),
        .s_buttons         (s_buttons),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_kind     (m_result_kind),
        .m_status          (m_status),
        .m_slot            (m_slot),
        .m_peer_addr       (m_peer_addr),
        .m_peer_port       (m_peer_port),
        .m_send_seq        (m_send_seq),
        .m_buttons_down    (m_buttons_down),
        .m_buttons_pressed (m_buttons_pressed),
        .m_last            (m_last)
    );

endmodule

>>> design/ust_ram.sv
module ust_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/ust_ctrl.sv
module ust_ctrl
    import ust_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DISPATCH = 9'b000000010,
        S_SCAN_RD  = 9'b000000100,
        S_SCAN_EV  = 9'b000001000,
        S_PKT_DEC  = 9'b000010000,
        S_PKT_OUT  = 9'b000100000,
        S_TICK_RD  = 9'b001000000,
        S_TICK_EV  = 9'b010000000,
        S_TICK_END = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                cmd.start = 1'b1;
                if (sts.kind_tick) begin
                    state_next = S_TICK_RD;
                end else if (sts.short_pkt) begin
                    cmd.hold_short = 1'b1;
                    state_next     = S_PKT_OUT;
                end else begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                state_next = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                cmd.scan_eval = 1'b1;
                if (sts.match || sts.last_idx) begin
                    state_next = S_PKT_DEC;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_PKT_DEC: begin
                cmd.commit = 1'b1;
                state_next = S_PKT_OUT;
            end
            S_PKT_OUT: begin
                if (sts.out_free) begin
                    cmd.push      = 1'b1;
                    cmd.push_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_TICK_RD: begin
                state_next = S_TICK_EV;
            end
            S_TICK_EV: begin
                if (!sts.live || sts.evict || !sts.hold_valid || sts.out_free) begin
                    if (sts.live && sts.evict) begin
                        cmd.evict = 1'b1;
                    end else if (sts.live) begin
                        cmd.tick_upd = 1'b1;
                        cmd.push     = sts.hold_valid;
                    end
                    if (sts.last_idx) begin
                        state_next = S_TICK_END;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_TICK_RD;
                    end
                end
            end
            S_TICK_END: begin
                if (!sts.hold_valid) begin
                    state_next = S_IDLE;
                end else if (sts.out_free) begin
                    cmd.push      = 1'b1;
                    cmd.push_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_idle_no_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !sts.hold_valid)
        else $error("pending result left behind when returning to idle");
`endif

endmodule

>>> design/ust_dp.sv
module ust_dp
    import ust_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic        s_kind,
    input  logic [31:0] s_src_addr,
    input  logic [15:0] s_src_port,
    input  logic [10:0] s_pkt_length,
    input  logic [31:0] s_seq_number,
    input  logic [7:0]  s_buttons,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [1:0]  m_status,
    output logic [5:0]  m_slot,
    output logic [31:0] m_peer_addr,
    output logic [15:0] m_peer_port,
    output logic [31:0] m_send_seq,
    output logic [7:0]  m_buttons_down,
    output logic [7:0]  m_buttons_pressed,
    output logic        m_last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic              in_kind_reg;
    logic [31:0]       in_addr_reg;
    logic [15:0]       in_port_reg;
    logic [10:0]       in_len_reg;
    logic [31:0]       in_seq_reg;
    logic [7:0]        in_btn_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              hit_found_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    entry_t            hit_entry_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic [31:0]       tick_reg;
    logic [15:0]       timeout_reg;
    logic [SLOTS-1:0]  live_reg;
    res_t              hold_reg;
    logic              hold_valid_reg;
    res_t              out_reg;
    logic              out_last_reg;
    logic              out_valid_reg;

    entry_t            rd_entry;
    logic [ENTRY_W-1:0] rd_bits;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    entry_t            ram_wdata;

    logic              cur_live;
    logic              cur_match;
    logic              cur_evict;
    logic              new_sess;
    logic              full;
    logic              stale;
    logic [IDX_W-1:0]  target;
    entry_t            base;
    entry_t            pkt_entry;
    entry_t            upd_entry;
    res_t              pkt_res;
    res_t              upd_res;
    res_t              short_res;

    ust_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (rd_bits)
    );

    assign rd_entry  = entry_t'(rd_bits);
    assign cur_live  = live_reg[idx_reg];
    assign cur_match = cur_live && (rd_entry.addr == in_addr_reg)
                       && (rd_entry.port == in_port_reg);
    assign cur_evict = (tick_reg - rd_entry.last_seen) > {16'd0, timeout_reg};

    always_comb begin
        new_sess = !hit_found_reg;
        full     = !hit_found_reg && !free_found_reg;
        target   = hit_found_reg ? hit_idx_reg : free_idx_reg;
        if (hit_found_reg) begin
            base = hit_entry_reg;
        end else begin
            base      = '0;
            base.addr = in_addr_reg;
            base.port = in_port_reg;
        end
        stale = (in_seq_reg <= base.recv_seq);

        pkt_entry = base;
        if (!stale) begin
            pkt_entry.last_seen = tick_reg;
            pkt_entry.recv_seq  = in_seq_reg;
            pkt_entry.pressed   = ~base.down & in_btn_reg;
            pkt_entry.down      = in_btn_reg;
        end

        upd_entry          = rd_entry;
        upd_entry.send_seq = rd_entry.send_seq + 32'd1;
        upd_entry.pressed  = 8'd0;

        pkt_res      = '0;
        pkt_res.kind = RK_STATUS;
        pkt_res.addr = in_addr_reg;
        pkt_res.port = in_port_reg;
        if (full) begin
            pkt_res.status = ST_FULL;
        end else begin
            pkt_res.status = stale ? ST_STALE : ST_ACCEPTED;
            pkt_res.slot   = 6'(target);
        end

        short_res        = '0;
        short_res.kind   = RK_STATUS;
        short_res.status = ST_SHORT;
        short_res.addr   = in_addr_reg;
        short_res.port   = in_port_reg;

        upd_res          = '0;
        upd_res.kind     = RK_UPDATE;
        upd_res.status   = ST_ACCEPTED;
        upd_res.slot     = 6'(idx_reg);
        upd_res.addr     = rd_entry.addr;
        upd_res.port     = rd_entry.port;
        upd_res.send_seq = upd_entry.send_seq;
        upd_res.down     = rd_entry.down;
        upd_res.pressed  = rd_entry.pressed;

        ram_we    = cmd.tick_upd || (cmd.commit && !full && (new_sess || !stale));
        ram_waddr = cmd.commit ? target : idx_reg;
        ram_wdata = cmd.commit ? pkt_entry : upd_entry;
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            in_kind_reg <= s_kind;
            in_addr_reg <= s_src_addr;
            in_port_reg <= s_src_port;
            in_len_reg  <= s_pkt_length;
            in_seq_reg  <= s_seq_number;
            in_btn_reg  <= s_buttons;
        end
        if (cmd.scan_eval && cur_match) begin
            hit_idx_reg   <= idx_reg;
            hit_entry_reg <= rd_entry;
        end
        if (cmd.scan_eval && !cur_live && !free_found_reg) begin
            free_idx_reg <= idx_reg;
        end
        if (cmd.hold_short) begin
            hold_reg <= short_res;
        end else if (cmd.commit) begin
            hold_reg <= pkt_res;
        end else if (cmd.tick_upd) begin
            hold_reg <= upd_res;
        end
        if (cmd.push) begin
            out_reg      <= hold_reg;
            out_last_reg <= cmd.push_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg        <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            tick_reg       <= '0;
            timeout_reg    <= TIMEOUT_RESET;
            live_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
            if (cmd.start) begin
                idx_reg        <= '0;
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
                if (in_kind_reg == KIND_TICK) begin
                    tick_reg <= tick_reg + 32'd1;
                end
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.scan_eval && cur_match) begin
                hit_found_reg <= 1'b1;
            end
            if (cmd.scan_eval && !cur_live) begin
                free_found_reg <= 1'b1;
            end
            if (cmd.commit && new_sess && !full) begin
                live_reg[target] <= 1'b1;
            end
            if (cmd.evict) begin
                live_reg[idx_reg] <= 1'b0;
            end
            if (cmd.hold_short || cmd.commit || cmd.tick_upd) begin
                hold_valid_reg <= 1'b1;
            end else if (cmd.push) begin
                hold_valid_reg <= 1'b0;
            end
            if (cmd.push) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        sts.kind_tick  = (in_kind_reg == KIND_TICK);
        sts.short_pkt  = (in_len_reg < MIN_PKT_LEN);
        sts.live       = cur_live;
        sts.match      = cur_match;
        sts.evict      = cur_evict;
        sts.last_idx   = (idx_reg == IDX_W'(SLOTS - 1));
        sts.hold_valid = hold_valid_reg;
        sts.out_free   = !out_valid_reg || m_ready;
    end

    assign m_valid           = out_valid_reg;
    assign m_result_kind     = out_reg.kind;
    assign m_status          = out_reg.status;
    assign m_slot            = out_reg.slot;
    assign m_peer_addr       = out_reg.addr;
    assign m_peer_port       = out_reg.port;
    assign m_send_seq        = out_reg.send_seq;
    assign m_buttons_down    = out_reg.down;
    assign m_buttons_pressed = out_reg.pressed;
    assign m_last            = out_last_reg;

`ifndef ASSERT_OFF
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> (!out_valid_reg || m_ready))
        else $error("result pushed over an untaken result");
    a_upd_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.tick_upd || cmd.evict) |-> cur_live)
        else $error("tick walk acted on a free slot");
    a_hit_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && hit_found_reg) |-> live_reg[hit_idx_reg])
        else $error("matched session is not live at commit");
`endif

endmodule
